/* rtl/button_debounce_toggle_hold_defines.svh */
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared property shapes for the checker of the button debounce block.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_TOGGLE_HOLD_DEFINES_SVH
`define BUTTON_DEBOUNCE_TOGGLE_HOLD_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BDTH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button debounce check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define BDTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button debounce check failed");

`endif

/* rtl/bdth_pkg.sv */
// ----------------------------------------------------------------------------
// bdth_pkg
// Types and constants shared by the button debounce block and its checker.
// ----------------------------------------------------------------------------
package bdth_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_HOLD_THR = 3'd1,
    CFG_IN_USE   = 3'd2,
    CFG_TYPE_MAP = 3'd3
  } cfg_reg_e;

  // Button type codes, two bits per button in the type map
  typedef enum logic [1:0] {
    KIND_IGNORE = 2'd0,
    KIND_ANALOG = 2'd1,
    KIND_DIRECT = 2'd2,
    KIND_TOGGLE = 2'd3
  } kind_e;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] HOLD_THR_RESET = 16'd1000;
  localparam logic [4:0]  IN_USE_RESET   = 5'd16;
  localparam logic [31:0] TYPE_MAP_RESET = 32'd0;

  // floor(x / 1000) = floor((x >> 3) * DIV125_MAGIC >> DIV125_SHIFT), exact for 32-bit x
  localparam logic [29:0] DIV125_MAGIC = 30'd549755814;
  localparam int          DIV125_SHIFT = 36;

  typedef struct packed {
    logic [3:0]  button_index;
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [3:0] result_index;
    logic       skipped;
    logic       output_state;
    logic       hold_active;
    logic [7:0] hold_seconds;
    logic       press_edge;
    logic       release_edge;
  } out_t;

  // Per-button state entry; hold time is kept in ms and turned into seconds
  // on the way out.
  typedef struct packed {
    logic        raw_seen;
    logic [31:0] raw_change_time;
    logic        debounced_level;
    logic        logical_output;
    logic        hold_flag;
    logic [31:0] held_ms;
    logic [31:0] hold_start_time;
  } entry_t;

  typedef struct packed {
    logic press_edge;
    logic release_edge;
  } edge_t;

endpackage

/* rtl/bdth_update.sv */
// ----------------------------------------------------------------------------
// bdth_update
// Next-state logic for one button entry: debounce, toggle and hold timing.
// ----------------------------------------------------------------------------
module bdth_update (
  input  bdth_pkg::entry_t cur,
  input  logic             pressed_now,
  input  logic [31:0]      now_ms,
  input  bdth_pkg::kind_e  kind,
  input  logic [15:0]      debounce_time_ms,
  input  logic [15:0]      hold_threshold_ms,
  output bdth_pkg::entry_t nxt,
  output bdth_pkg::edge_t  edges
);

  logic [31:0] stable_ms;
  logic [31:0] held_ms;

  always_comb begin
    nxt = cur;
    if (pressed_now != cur.raw_seen) begin
      nxt.raw_seen        = pressed_now;
      nxt.raw_change_time = now_ms;
    end

    stable_ms = now_ms - nxt.raw_change_time;
    if ((nxt.raw_seen != cur.debounced_level) &&
        (stable_ms >= {16'd0, debounce_time_ms})) begin
      nxt.debounced_level = nxt.raw_seen;
    end

    edges.press_edge   = nxt.debounced_level & ~cur.debounced_level;
    edges.release_edge = ~nxt.debounced_level & cur.debounced_level;

    held_ms = now_ms - cur.hold_start_time;
    if (kind == bdth_pkg::KIND_DIRECT) begin
      nxt.logical_output = nxt.debounced_level;
    end else begin
      if (edges.press_edge) begin
        nxt.logical_output  = ~cur.logical_output;
        nxt.hold_start_time = now_ms;
        nxt.hold_flag       = 1'b0;
        nxt.held_ms         = '0;
        held_ms             = '0;
      end
      if (nxt.debounced_level) begin
        if (held_ms >= {16'd0, hold_threshold_ms}) begin
          nxt.hold_flag = 1'b1;
          nxt.held_ms   = held_ms;
        end
      end else if (edges.release_edge) begin
        nxt.hold_flag = 1'b0;
        nxt.held_ms   = '0;
      end
    end
  end

endmodule

/* rtl/bdth_sec_div.sv */
// ----------------------------------------------------------------------------
// bdth_sec_div
// Whole seconds of a millisecond count, low eight bits, by reciprocal multiply.
// ----------------------------------------------------------------------------
module bdth_sec_div (
  input  logic [31:0] held_ms,
  output logic [7:0]  hold_seconds
);

  logic [58:0] product;

  // x / 1000 = (x / 8) / 125; the low three bits never reach the quotient
  assign product      = 59'(held_ms[31:3]) * 59'(bdth_pkg::DIV125_MAGIC);
  assign hold_seconds = product[bdth_pkg::DIV125_SHIFT +: 8];

endmodule

/* rtl/button_debounce_toggle_hold.sv */
// ----------------------------------------------------------------------------
// button_debounce_toggle_hold
// Per-button debounce with direct or toggle output and long-press hold report.
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  transaction
//  --------  -------------------------------  ---------  ---------------------
//  in        in_valid / in_ready / in_data    sink       one scan sample
//  out       out_valid / out_ready / out_data source     one result per sample
//  cfg       cfg_valid / cfg_ready / cfg_*    sink       one register write
//
//  One sample per cycle, sustained while out is not stalled. A result passes
//  through the memory read at the accepting edge, then the state update
//  into stage 2, then the seconds multiply into the output register.
//  The rate is set by the single state memory: each sample reads its entry
//  when accepted and writes it back from stage 1, with a forwarding register
//  covering back-to-back samples of the same button.
//  Reset clears the per-entry valid bits at once; no clearing pass is needed.
//  A stall on out freezes the whole pipeline and drops in_ready.
//
module button_debounce_toggle_hold #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic             clk,
  input  logic             rst,

  input  logic             in_valid,
  output logic             in_ready,
  input  bdth_pkg::in_t    in_data,

  output logic             out_valid,
  input  logic             out_ready,
  output bdth_pkg::out_t   out_data,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] debounce_time_ms;
  logic [15:0] hold_threshold_ms;
  logic [4:0]  buttons_in_use;
  logic [31:0] button_type_map;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time_ms  <= bdth_pkg::DEBOUNCE_RESET;
      hold_threshold_ms <= bdth_pkg::HOLD_THR_RESET;
      buttons_in_use    <= bdth_pkg::IN_USE_RESET;
      button_type_map   <= bdth_pkg::TYPE_MAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdth_pkg::CFG_DEBOUNCE: debounce_time_ms  <= cfg_data[15:0];
        bdth_pkg::CFG_HOLD_THR: hold_threshold_ms <= cfg_data[15:0];
        bdth_pkg::CFG_IN_USE:   buttons_in_use    <= cfg_data[4:0];
        bdth_pkg::CFG_TYPE_MAP: button_type_map   <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless out is stalled
  // --------------------------------------------------------------------------
  logic advance;
  logic in_fire;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign in_fire  = in_valid && advance;

  logic [AW-1:0] in_addr;
  assign in_addr = AW'(in_data.button_index);

  // --------------------------------------------------------------------------
  // State memory, one entry per button, registered read
  // --------------------------------------------------------------------------
  bdth_pkg::entry_t        mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  ent_valid;   // entry written since reset
  bdth_pkg::entry_t        rd_data;
  logic                    rd_valid;

  logic                    wr_en;
  logic [AW-1:0]           s1_addr;
  bdth_pkg::entry_t        upd_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= upd_next;
    end
    if (in_fire) begin
      rd_data  <= mem[in_addr];
      rd_valid <= ent_valid[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[s1_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: state update and write-back
  // --------------------------------------------------------------------------
  logic             s1_valid;
  bdth_pkg::in_t    s1_in;
  logic             s1_fwd;        // read raced a write to the same entry
  bdth_pkg::entry_t s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      if (in_fire) begin
        // The entry being written this edge is newer than what the read saw
        s1_fwd <= wr_en && (s1_addr == in_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in       <= in_data;
      s1_fwd_data <= upd_next;
    end
  end

  assign s1_addr = AW'(s1_in.button_index);

  bdth_pkg::entry_t cur;
  bdth_pkg::kind_e  s1_kind;
  logic             s1_skip;
  bdth_pkg::edge_t  s1_edges;

  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_data;
    end else if (rd_valid) begin
      cur = rd_data;
    end else begin
      cur = '0;  // never written: reset state, released with zero times
    end
  end

  assign s1_kind = bdth_pkg::kind_e'(button_type_map[{s1_in.button_index, 1'b0} +: 2]);

  // Skip unused, out-of-range, ignored and analog buttons
  assign s1_skip = ({1'b0, s1_in.button_index} >= buttons_in_use) ||
                   (7'(s1_in.button_index) >= 7'(NUM_BUTTONS)) ||
                   (s1_kind == bdth_pkg::KIND_IGNORE) ||
                   (s1_kind == bdth_pkg::KIND_ANALOG);

  bdth_update u_update (
    .cur               (cur),
    .pressed_now       (~s1_in.pin_level),
    .now_ms            (s1_in.now_ms),
    .kind              (s1_kind),
    .debounce_time_ms  (debounce_time_ms),
    .hold_threshold_ms (hold_threshold_ms),
    .nxt               (upd_next),
    .edges             (s1_edges)
  );

  assign wr_en = s1_valid && advance && !s1_skip;

  // --------------------------------------------------------------------------
  // Stage 2: result fields, hold time still in ms
  // --------------------------------------------------------------------------
  logic           s2_valid;
  bdth_pkg::out_t s2_res;
  logic [31:0]    s2_held_ms;
  bdth_pkg::out_t s2_res_next;
  logic [31:0]    s2_held_ms_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    s2_res_next              = '0;
    s2_res_next.result_index = s1_in.button_index;
    s2_held_ms_next          = '0;
    if (s1_skip) begin
      s2_res_next.skipped = 1'b1;
    end else begin
      s2_res_next.output_state = upd_next.logical_output;
      s2_res_next.hold_active  = upd_next.hold_flag;
      s2_res_next.press_edge   = s1_edges.press_edge;
      s2_res_next.release_edge = s1_edges.release_edge;
      s2_held_ms_next          = upd_next.held_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_res     <= s2_res_next;
      s2_held_ms <= s2_held_ms_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: seconds from the held ms count
  // --------------------------------------------------------------------------
  logic [7:0]     s2_seconds;
  bdth_pkg::out_t out_data_next;

  bdth_sec_div u_sec_div (
    .held_ms      (s2_held_ms),
    .hold_seconds (s2_seconds)
  );

  always_comb begin
    out_data_next              = s2_res;
    out_data_next.hold_seconds = s2_seconds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* rtl/bdth_checker.sv */
// ----------------------------------------------------------------------------
// bdth_checker
// Port-level checks on the result stream of the button debounce block.
// ----------------------------------------------------------------------------
`include "button_debounce_toggle_hold_defines.svh"

module bdth_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input bdth_pkg::out_t out_data
);

  logic fields_clear;
  logic has_secs;

  assign fields_clear = !out_data.output_state && !out_data.hold_active &&
                        (out_data.hold_seconds == 8'd0) &&
                        !out_data.press_edge && !out_data.release_edge;
  assign has_secs     = out_valid && (out_data.hold_seconds != 8'd0);

  // A skipped button reports nothing but its index
  `BDTH_ASSERT_NOW(a_skip_clean, out_valid && out_data.skipped, fields_clear)

  // One debounced step cannot both press and release
  `BDTH_ASSERT_NOW(a_edge_excl, out_valid, !(out_data.press_edge && out_data.release_edge))

  // Held seconds are only ever stored together with the hold flag
  `BDTH_ASSERT_NOW(a_sec_has_hold, has_secs, out_data.hold_active)

  // Hold a stalled result
  `BDTH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind button_debounce_toggle_hold bdth_checker u_bdth_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
